FILE: rtl/core/rbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbr_pkg
// Shared constants, codes and the arctangent table for the relative bearing
// and range pipeline.
// ----------------------------------------------------------------------------
package rbr_pkg;

  // Default sizes handed to the top level.
  localparam int COORD_BITS_DEF    = 24;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Fraction bits carried below the millimetre in the datapath.
  localparam int GUARD = 8;
  // Extra integer bits above sign for CORDIC growth (two chains, sqrt(2) input).
  localparam int HEADROOM = 3;

  // Internal angle width: 2^31 is pi, wraps mod 2^32.
  localparam int ZW = 32;
  localparam logic [ZW-1:0] ANGLE_PI = 32'h8000_0000;

  // 1/K of the CORDIC gain in Q16.
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  localparam int ATAN_ENTRIES = 24;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAR_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAR_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAR_HEADING = 2'd2;

  typedef enum logic {
    CORDIC_ROTATE = 1'b0,
    CORDIC_VECTOR = 1'b1
  } cordic_mode_e;

  // atan(2^-i) in binary angle units, 2^31 = pi.
  function automatic logic [ZW-1:0] atan_angle(input int unsigned i);
    logic [ZW-1:0] a;
    case (i)
      0:       a = 32'd536870912;
      1:       a = 32'd316933406;
      2:       a = 32'd167458907;
      3:       a = 32'd85004756;
      4:       a = 32'd42667331;
      5:       a = 32'd21354465;
      6:       a = 32'd10679838;
      7:       a = 32'd5340245;
      8:       a = 32'd2670163;
      9:       a = 32'd1335087;
      10:      a = 32'd667544;
      11:      a = 32'd333772;
      12:      a = 32'd166886;
      13:      a = 32'd83443;
      14:      a = 32'd41722;
      15:      a = 32'd20861;
      16:      a = 32'd10430;
      17:      a = 32'd5215;
      18:      a = 32'd2608;
      19:      a = 32'd1304;
      20:      a = 32'd652;
      21:      a = 32'd326;
      22:      a = 32'd163;
      23:      a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/rbr_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbr_cordic_stage
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module rbr_cordic_stage #(
  parameter int                   W     = 36,
  parameter int unsigned          SHIFT = 0,
  parameter rbr_pkg::cordic_mode_e MODE = rbr_pkg::CORDIC_ROTATE
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [W-1:0]      x_i,
  input  logic signed [W-1:0]      y_i,
  input  logic [rbr_pkg::ZW-1:0]   z_i,
  output logic                     valid_o,
  output logic signed [W-1:0]      x_o,
  output logic signed [W-1:0]      y_o,
  output logic [rbr_pkg::ZW-1:0]   z_o
);
  import rbr_pkg::*;

  localparam logic [ZW-1:0] ATAN = atan_angle(SHIFT);

  logic                 valid_q;
  logic signed [W-1:0]  x_d, y_d, x_q, y_q;
  logic [ZW-1:0]        z_d, z_q;
  logic signed [W-1:0]  xs, ys;
  logic                 up;

  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  // up: rotate counterclockwise this step.
  assign up = (MODE == CORDIC_ROTATE) ? !z_i[ZW-1] : y_i[W-1];

  always_comb begin
    if (up) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
    end
    // Rotation drives z toward zero; vectoring accumulates the angle removed.
    if (up) begin
      z_d = z_i - ATAN;
    end else begin
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

FILE: rtl/core/relative_bearing_and_range.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_bearing_and_range
// Bearing and forward distance of a global point seen from the vehicle pose.
// ----------------------------------------------------------------------------
// A point is taken at every clock edge where start is high and busy is low;
// busy never rises, so one point per clock is accepted without gaps. Each
// point yields one word on bearing_o / forward_distance_o, marked by a single
// cycle of result_valid_o, in input order. The pipeline is made of the two
// unrolled CORDIC chains (rotation into the vehicle frame, then vectoring for
// atan2), one register per micro-rotation, plus the offset, quadrant, setup
// and rounding stages. The receiver cannot stall results, and the pipeline
// never holds back. The pose registers car_x, car_y and car_heading are
// written through the cfg port, which is always ready; write them only while
// no point is in flight.
// ----------------------------------------------------------------------------
module relative_bearing_and_range #(
  parameter int COORD_BITS    = rbr_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS    = rbr_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = rbr_pkg::CORDIC_STAGES_DEF,
  // Derived: config data width, widest register.
  parameter int CFG_W         = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command side
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_BITS-1:0]    point_x_i,
  input  logic signed [COORD_BITS-1:0]    point_y_i,
  // Result side
  output logic                            result_valid_o,
  output logic signed [ANGLE_BITS-1:0]    bearing_o,
  output logic signed [COORD_BITS:0]      forward_distance_o,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rbr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]                cfg_data_i
);
  import rbr_pkg::*;

  // Datapath width: offset (COORD_BITS+1) + guard fraction + growth headroom.
  localparam int W  = COORD_BITS + 1 + GUARD + HEADROOM;
  // Product and rounded-sum widths for the gain correction.
  localparam int PW = W + 17;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] FD_ROUND = SW'(1) <<< (15 + GUARD);
  localparam int N  = CORDIC_STAGES;

  // --------------------------------------------------------------------------
  // Pose registers
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] car_x_q, car_y_q;
  logic [ANGLE_BITS-1:0]        car_heading_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_x_q       <= '0;
      car_y_q       <= '0;
      car_heading_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CAR_X:       car_x_q       <= cfg_data_i[COORD_BITS-1:0];
        CFG_CAR_Y:       car_y_q       <= cfg_data_i[COORD_BITS-1:0];
        CFG_CAR_HEADING: car_heading_q <= cfg_data_i[ANGLE_BITS-1:0];
        default: ;  // unknown index: drop the word
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: offset from the vehicle and rotation angle (minus heading)
  // --------------------------------------------------------------------------
  logic                       s1_valid_q;
  logic signed [COORD_BITS:0] s1_dx_q, s1_dy_q;
  logic [ZW-1:0]              s1_z_q;
  logic [ANGLE_BITS-1:0]      neg_heading;

  assign neg_heading = ANGLE_BITS'(-car_heading_q);

  always_ff @(posedge clk_i) begin
    s1_dx_q <= {point_x_i[COORD_BITS-1], point_x_i} - {car_x_q[COORD_BITS-1], car_x_q};
    s1_dy_q <= {point_y_i[COORD_BITS-1], point_y_i} - {car_y_q[COORD_BITS-1], car_y_q};
    s1_z_q  <= {neg_heading, {(ZW-ANGLE_BITS){1'b0}}};
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale to guard precision, fold angle into [-pi/2, pi/2)
  // --------------------------------------------------------------------------
  logic                 s2_valid_q;
  logic signed [W-1:0]  s2_x_q, s2_y_q;
  logic [ZW-1:0]        s2_z_q;
  logic signed [W-1:0]  sc_x, sc_y;
  logic                 fold;

  assign sc_x = {{HEADROOM{s1_dx_q[COORD_BITS]}}, s1_dx_q, {GUARD{1'b0}}};
  assign sc_y = {{HEADROOM{s1_dy_q[COORD_BITS]}}, s1_dy_q, {GUARD{1'b0}}};
  assign fold = s1_z_q[ZW-1] ^ s1_z_q[ZW-2];

  always_ff @(posedge clk_i) begin
    s2_x_q <= fold ? -sc_x : sc_x;
    s2_y_q <= fold ? -sc_y : sc_y;
    s2_z_q <= fold ? (s1_z_q + ANGLE_PI) : s1_z_q;
  end

  // --------------------------------------------------------------------------
  // Rotation chain: offset into the vehicle frame
  // --------------------------------------------------------------------------
  logic                 rot_v [N+1];
  logic signed [W-1:0]  rot_x [N+1];
  logic signed [W-1:0]  rot_y [N+1];
  logic [ZW-1:0]        rot_z [N+1];

  assign rot_v[0] = s2_valid_q;
  assign rot_x[0] = s2_x_q;
  assign rot_y[0] = s2_y_q;
  assign rot_z[0] = s2_z_q;

  for (genvar i = 0; i < N; i++) begin : g_rot
    rbr_cordic_stage #(
      .W     (W),
      .SHIFT (i),
      .MODE  (CORDIC_ROTATE)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rot_v[i]),
      .x_i     (rot_x[i]),
      .y_i     (rot_y[i]),
      .z_i     (rot_z[i]),
      .valid_o (rot_v[i+1]),
      .x_o     (rot_x[i+1]),
      .y_o     (rot_y[i+1]),
      .z_o     (rot_z[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Setup stage: zero-vector flag, vectoring half-plane fold, gain multiply
  // --------------------------------------------------------------------------
  logic                 sv_valid_q;
  logic signed [W-1:0]  sv_x_q, sv_y_q;
  logic [ZW-1:0]        sv_z_q;
  logic signed [PW-1:0] prod_q;
  logic                 loc_neg;
  logic signed [W-1:0]  loc_x, loc_y;

  assign loc_x   = rot_x[N];
  assign loc_y   = rot_y[N];
  assign loc_neg = loc_x[W-1];

  // Zero flag travels beside the vectoring chain.
  logic zero_dly [N+1];

  always_ff @(posedge clk_i) begin
    sv_x_q      <= loc_neg ? -loc_x : loc_x;
    sv_y_q      <= loc_neg ? -loc_y : loc_y;
    sv_z_q      <= loc_neg ? ANGLE_PI : '0;
    prod_q      <= loc_x * $signed({1'b0, INV_GAIN_Q16});
  end

  // --------------------------------------------------------------------------
  // Forward distance: round, shift, saturate, then delay to meet the bearing
  // --------------------------------------------------------------------------
  logic signed [SW-1:0]   fd_sum, fd_shr;
  logic signed [COORD_BITS:0] fd_sat;
  logic                   fd_in_range;
  logic signed [COORD_BITS:0] fd_dly [N];

  assign fd_sum      = {prod_q[PW-1], prod_q} + FD_ROUND;
  assign fd_shr      = fd_sum >>> (16 + GUARD);
  assign fd_in_range = (&fd_shr[SW-1:COORD_BITS]) || !(|fd_shr[SW-1:COORD_BITS]);

  always_comb begin
    if (fd_in_range) begin
      fd_sat = fd_shr[COORD_BITS:0];
    end else if (fd_shr[SW-1]) begin
      fd_sat = {1'b1, {COORD_BITS{1'b0}}};
    end else begin
      fd_sat = {1'b0, {COORD_BITS{1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    fd_dly[0]   <= fd_sat;
    for (int k = 1; k < N; k++) begin
      fd_dly[k] <= fd_dly[k-1];
    end
    zero_dly[0] <= (loc_x == '0) && (loc_y == '0);
    for (int k = 1; k <= N; k++) begin
      zero_dly[k] <= zero_dly[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Vectoring chain: atan2 of the local vector
  // --------------------------------------------------------------------------
  logic                 vec_v [N+1];
  logic signed [W-1:0]  vec_x [N+1];
  logic signed [W-1:0]  vec_y [N+1];
  logic [ZW-1:0]        vec_z [N+1];

  assign vec_v[0] = sv_valid_q;
  assign vec_x[0] = sv_x_q;
  assign vec_y[0] = sv_y_q;
  assign vec_z[0] = sv_z_q;

  for (genvar i = 0; i < N; i++) begin : g_vec
    rbr_cordic_stage #(
      .W     (W),
      .SHIFT (i),
      .MODE  (CORDIC_VECTOR)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vec_v[i]),
      .x_i     (vec_x[i]),
      .y_i     (vec_y[i]),
      .z_i     (vec_z[i]),
      .valid_o (vec_v[i+1]),
      .x_o     (vec_x[i+1]),
      .y_o     (vec_y[i+1]),
      .z_o     (vec_z[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: round the bearing, force zero for a zero vector
  // --------------------------------------------------------------------------
  logic                          out_valid_q;
  logic signed [ANGLE_BITS-1:0]  bearing_q;
  logic signed [COORD_BITS:0]    fd_q;
  logic [ZW-1:0]                 bz_round;

  assign bz_round = vec_z[N] + (ZW'(1) << (ZW - 1 - ANGLE_BITS));

  // Load only on a result so the ports hold between words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bearing_q <= '0;
      fd_q      <= '0;
    end else if (vec_v[N]) begin
      bearing_q <= zero_dly[N] ? '0 : bz_round[ZW-1 -: ANGLE_BITS];
      fd_q      <= fd_dly[N-1];
    end
  end

  // Valid bits of the non-CORDIC stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      sv_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= start && !busy;
      s2_valid_q  <= s1_valid_q;
      sv_valid_q  <= rot_v[N];
      out_valid_q <= vec_v[N];
    end
  end

  assign result_valid_o     = out_valid_q;
  assign bearing_o          = bearing_q;
  assign forward_distance_o = fd_q;

endmodule

FILE: rtl/core/rbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbr_checker
// Port-level checks on the relative bearing and range pipeline, bound to
// the top level.
// ----------------------------------------------------------------------------
module rbr_checker #(
  parameter int COORD_BITS    = rbr_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS    = rbr_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = rbr_pkg::CORDIC_STAGES_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           result_valid_o,
  input logic signed [ANGLE_BITS-1:0]   bearing_o,
  input logic signed [COORD_BITS:0]     forward_distance_o
);

  localparam int LAT   = 4 + 2 * CORDIC_STAGES;
  localparam int AGE_W = $clog2(LAT + 1);

  // Cycles since reset, saturating at the pipeline latency.
  logic [AGE_W-1:0] age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else if (age_q != AGE_W'(LAT)) begin
      age_q <= age_q + 1'b1;
    end
  end

  // Every accepted point comes out after the pipeline latency, and nothing else does.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_q == AGE_W'(LAT)) |-> (result_valid_o == $past(start && !busy, LAT)))
    else $error("result strobe does not match an accepted point");

  // Before a point could have passed through, no result shows.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_q != AGE_W'(LAT)) |-> !result_valid_o)
    else $error("result strobe before the pipeline could fill");

  // The pipeline never refuses a point.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // Result ports change only with a new result.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> ($stable(bearing_o) && $stable(forward_distance_o)))
    else $error("result ports changed without a strobe");

endmodule

bind relative_bearing_and_range rbr_checker #(
  .COORD_BITS    (COORD_BITS),
  .ANGLE_BITS    (ANGLE_BITS),
  .CORDIC_STAGES (CORDIC_STAGES)
) u_rbr_checker (.*);

FILE: sim/tb_relative_bearing_and_range.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_relative_bearing_and_range
// Self-checking bench for the relative bearing and range pipeline.
// ----------------------------------------------------------------------------
// A clocked driver feeds points and pose register writes from a queue that is
// built at time zero. The bench starts with a short directed list: field
// extremes, the zero local vector, saturating distances, a heading of -pi,
// bearings close to pi, the quadrant boundaries and a write to an unused
// register index. Random phases follow, each after random writes to some pose registers.
// A clocked monitor predicts the bearing and forward distance of every
// accepted point with its own CORDIC model and checks each result word
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_relative_bearing_and_range;

  localparam int COORD_BITS    = 24;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int CFG_W         = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

  // Pipeline depth of the block, from its two CORDIC chains and other stages.
  localparam int LATENCY       = 4 + 2 * CORDIC_STAGES;

  localparam int GUARD_BITS    = 8;
  localparam longint INV_GAIN  = 39797;
  localparam int ATAN_DEPTH    = 24;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  localparam longint FWD_MAX   = (longint'(1) << COORD_BITS) - 1;
  localparam longint FWD_MIN   = -(longint'(1) << COORD_BITS);

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [ANGLE_BITS-1:0] HEAD_MAX  = {1'b0, {(ANGLE_BITS-1){1'b1}}};
  localparam logic signed [ANGLE_BITS-1:0] HEAD_MIN  = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam logic signed [ANGLE_BITS-1:0] QUARTER   = ANGLE_BITS'(1 <<< (ANGLE_BITS - 2));
  localparam logic signed [ANGLE_BITS-1:0] EIGHTH    = ANGLE_BITS'(1 <<< (ANGLE_BITS - 3));

  // Index with no register behind it; the block must drop such writes.
  localparam logic [rbr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int RANDOM_POINTS = 850;
  localparam int TAIL_NO_GAP   = 120;
  localparam int MAX_REPORTS   = 200;
  localparam int DRAIN_LIMIT   = 4 * LATENCY + 100;

  typedef enum logic [1:0] {
    ITEM_POINT,
    ITEM_CFG,
    ITEM_DRAIN
  } stim_kind_e;

  typedef struct {
    stim_kind_e                     kind;
    logic signed [COORD_BITS-1:0]   px;
    logic signed [COORD_BITS-1:0]   py;
    logic [rbr_pkg::CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]               data;
  } stim_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0]   bearing;
    logic signed [COORD_BITS:0]     fwd_dist;
  } bearing_range_t;

  // DUT ports; every input is known from time zero.
  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            start          = 1'b0;
  logic                            busy;
  logic signed [COORD_BITS-1:0]    point_x_i      = '0;
  logic signed [COORD_BITS-1:0]    point_y_i      = '0;
  logic                            result_valid_o;
  logic signed [ANGLE_BITS-1:0]    bearing_o;
  logic signed [COORD_BITS:0]      forward_distance_o;
  logic                            cfg_valid_i    = 1'b0;
  logic                            cfg_ready_o;
  logic [rbr_pkg::CFG_IDX_W-1:0]   cfg_index_i    = '0;
  logic [CFG_W-1:0]                cfg_data_i     = '0;

  // atan(2^-i) with 2^31 standing for pi.
  logic [31:0] atan_lut [0:ATAN_DEPTH-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  stim_t          stim_q [$];
  bearing_range_t bearing_range_q [$];

  // Pose as the stimulus plan sees it, used to aim points near the vehicle.
  logic signed [COORD_BITS-1:0] plan_car_x = '0;
  logic signed [COORD_BITS-1:0] plan_car_y = '0;

  // Pose as the monitor tracks it from accepted register writes.
  logic signed [COORD_BITS-1:0] pose_x;
  logic signed [COORD_BITS-1:0] pose_y;
  logic signed [ANGLE_BITS-1:0] pose_heading;

  int  gap_left;
  int  outstanding;
  int  err_count = 0;
  bit  stim_done;
  bit  pt_fire;
  bit  cfg_fire;

  relative_bearing_and_range #(
    .COORD_BITS    (COORD_BITS),
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .point_x_i          (point_x_i),
    .point_y_i          (point_y_i),
    .result_valid_o     (result_valid_o),
    .bearing_o          (bearing_o),
    .forward_distance_o (forward_distance_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction: rotate the offset by minus the heading, then vector it for
  // atan2. Shifts floor toward minus infinity, angles wrap mod 2^32.
  // --------------------------------------------------------------------------
  function automatic bearing_range_t predict_bearing_range(
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py,
    input logic signed [COORD_BITS-1:0] cx,
    input logic signed [COORD_BITS-1:0] cy,
    input logic signed [ANGLE_BITS-1:0] hd
  );
    longint               rx;
    longint               ry;
    longint               nx;
    longint               ny;
    longint               fd;
    logic [ANGLE_BITS-1:0] neg_hd;
    logic [31:0]          z;
    logic [31:0]          bz;
    bearing_range_t       res;

    rx = (longint'(px) - longint'(cx)) * (longint'(1) << GUARD_BITS);
    ry = (longint'(py) - longint'(cy)) * (longint'(1) << GUARD_BITS);
    neg_hd = '0 - hd;
    z = 32'(neg_hd) << (32 - ANGLE_BITS);

    // Fold the rotation angle into [-pi/2, pi/2) by negating the vector.
    if (z[31] != z[30]) begin
      rx = -rx;
      ry = -ry;
      z  = z + HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_DEPTH; i++) begin
      if (!z[31]) begin
        nx = rx - (ry >>> i);
        ny = ry + (rx >>> i);
        z  = z - atan_lut[i];
      end else begin
        nx = rx + (ry >>> i);
        ny = ry - (rx >>> i);
        z  = z + atan_lut[i];
      end
      rx = nx;
      ry = ny;
    end

    // Drop the CORDIC gain, round, clamp to the output range.
    fd = (rx * INV_GAIN + (longint'(1) << (15 + GUARD_BITS))) >>> (16 + GUARD_BITS);
    if (fd > FWD_MAX) fd = FWD_MAX;
    if (fd < FWD_MIN) fd = FWD_MIN;
    res.fwd_dist = fd[COORD_BITS:0];

    // A vector at the origin has no direction: report zero.
    if (rx == 0 && ry == 0) begin
      res.bearing = '0;
    end else begin
      bz = '0;
      if (rx < 0) begin
        rx = -rx;
        ry = -ry;
        bz = HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_DEPTH; i++) begin
        if (ry >= 0) begin
          nx = rx + (ry >>> i);
          ny = ry - (rx >>> i);
          bz = bz + atan_lut[i];
        end else begin
          nx = rx - (ry >>> i);
          ny = ry + (rx >>> i);
          bz = bz - atan_lut[i];
        end
        rx = nx;
        ry = ny;
      end
      // Round half up and keep the top bits; just below pi wraps to -pi.
      bz = bz + (32'd1 << (31 - ANGLE_BITS));
      res.bearing = bz[31 -: ANGLE_BITS];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus plan helpers
  // --------------------------------------------------------------------------
  task automatic queue_point(input logic signed [COORD_BITS-1:0] px,
                             input logic signed [COORD_BITS-1:0] py);
    stim_t s;
    s.kind = ITEM_POINT;
    s.px   = px;
    s.py   = py;
    s.idx  = '0;
    s.data = '0;
    stim_q.push_back(s);
  endtask

  task automatic queue_cfg(input logic [rbr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] data);
    stim_t s;
    s.kind = ITEM_CFG;
    s.px   = '0;
    s.py   = '0;
    s.idx  = idx;
    s.data = data;
    stim_q.push_back(s);
    // Track the pose so later points can be aimed close to the vehicle.
    if (idx == rbr_pkg::CFG_CAR_X) plan_car_x = data[COORD_BITS-1:0];
    if (idx == rbr_pkg::CFG_CAR_Y) plan_car_y = data[COORD_BITS-1:0];
  endtask

  task automatic queue_drain();
    stim_t s;
    s.kind = ITEM_DRAIN;
    s.px   = '0;
    s.py   = '0;
    s.idx  = '0;
    s.data = '0;
    stim_q.push_back(s);
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    logic signed [COORD_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = COORD_MAX;
          1:       v = COORD_MIN;
          2:       v = 1;
          3:       v = -1;
          default: v = '0;
        endcase
      end
      1, 2: v = COORD_BITS'($signed($urandom_range(0, 10000)) - 5000);
      default: v = COORD_BITS'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic signed [ANGLE_BITS-1:0] pick_heading();
    logic signed [ANGLE_BITS-1:0] h;
    case ($urandom_range(0, 11))
      0:       h = HEAD_MAX;
      1:       h = HEAD_MIN;
      2:       h = QUARTER;
      3:       h = -QUARTER;
      4:       h = EIGHTH;
      5:       h = '0;
      default: h = ANGLE_BITS'($urandom());
    endcase
    return h;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] near_coord(
    input logic signed [COORD_BITS-1:0] base,
    input int span
  );
    return COORD_BITS'(int'(base) + $signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present one queued item at a time. Hold a word until its
  // handshake, write pose registers only with nothing in flight, and drop in
  // random gaps before points except near the end of the run.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      point_x_i   <= '0;
      point_y_i   <= '0;
      cfg_valid_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i  <= '0;
      gap_left    <= 0;
      stim_done   <= 1'b0;
    end else begin
      pt_fire  = start && !busy;
      cfg_fire = cfg_valid_i && cfg_ready_o;
      if (pt_fire || cfg_fire) begin
        void'(stim_q.pop_front());
      end

      if ((start && !pt_fire) || (cfg_valid_i && !cfg_fire)) begin
        // Hold the current word until it is taken.
      end else if (gap_left != 0) begin
        start       <= 1'b0;
        cfg_valid_i <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (stim_q.size() == 0) begin
        start       <= 1'b0;
        cfg_valid_i <= 1'b0;
        stim_done   <= 1'b1;
      end else begin
        case (stim_q[0].kind)
          ITEM_POINT: begin
            cfg_valid_i <= 1'b0;
            if (stim_q.size() > TAIL_NO_GAP && $urandom_range(0, 7) == 0) begin
              start    <= 1'b0;
              gap_left <= $urandom_range(0, 11);
            end else begin
              start     <= 1'b1;
              point_x_i <= stim_q[0].px;
              point_y_i <= stim_q[0].py;
            end
          end
          ITEM_CFG: begin
            start <= 1'b0;
            // Write the pose only once the pipeline has emptied.
            if (!pt_fire && outstanding == 0) begin
              cfg_valid_i <= 1'b1;
              cfg_index_i <= stim_q[0].idx;
              cfg_data_i  <= stim_q[0].data;
            end else begin
              cfg_valid_i <= 1'b0;
            end
          end
          default: begin
            // Pause the sender until every pending result word has come.
            start       <= 1'b0;
            cfg_valid_i <= 1'b0;
            if (!pt_fire && outstanding == 0) begin
              void'(stim_q.pop_front());
            end
          end
        endcase
      end
    end
  end

  task automatic note_mismatch(input string field, input longint exp_v, input longint act_v);
    $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: check each result word against the oldest prediction first,
  // then track pose writes and predict the point accepted at this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_x       = '0;
      pose_y       = '0;
      pose_heading = '0;
      outstanding <= 0;
    end else begin
      if (result_valid_o) begin
        if (bearing_range_q.size() == 0) begin
          if (err_count < MAX_REPORTS) begin
            $error("result word with nothing pending: bearing %0d, forward_distance %0d",
                   bearing_o, forward_distance_o);
          end
          err_count++;
        end else begin
          if (bearing_range_q[0].bearing !== bearing_o) begin
            note_mismatch("bearing", longint'(bearing_range_q[0].bearing),
                          longint'(bearing_o));
          end
          if (bearing_range_q[0].fwd_dist !== forward_distance_o) begin
            note_mismatch("forward_distance", longint'(bearing_range_q[0].fwd_dist),
                          longint'(forward_distance_o));
          end
          void'(bearing_range_q.pop_front());
        end
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rbr_pkg::CFG_CAR_X:       pose_x       = cfg_data_i[COORD_BITS-1:0];
          rbr_pkg::CFG_CAR_Y:       pose_y       = cfg_data_i[COORD_BITS-1:0];
          rbr_pkg::CFG_CAR_HEADING: pose_heading = cfg_data_i[ANGLE_BITS-1:0];
          default: ;
        endcase
      end

      if (start && !busy) begin
        bearing_range_q.push_back(predict_bearing_range(point_x_i, point_y_i,
                                                        pose_x, pose_y, pose_heading));
      end
      outstanding <= bearing_range_q.size();
    end
  end

  // Hard stop in case the pipeline stalls or drops words.
  initial begin
    #2_000_000;
    $display("tb_relative_bearing_and_range: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Build the plan, run reset, wait for the pipeline to empty, report.
  // --------------------------------------------------------------------------
  initial begin
    int                           n_rand;
    int                           phase_len;
    int                           waited;
    logic [CFG_W-1:0]             cfg_word;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;

    // Directed: field extremes and the zero vector under the reset pose.
    queue_point('0, '0);
    queue_point(COORD_MAX, '0);
    queue_point(COORD_MIN, '0);
    queue_point('0, COORD_MAX);
    queue_point('0, COORD_MIN);
    queue_point(COORD_MAX, COORD_MAX);
    queue_point(COORD_MIN, COORD_MIN);
    queue_point(COORD_MAX, COORD_MIN);
    queue_point(COORD_MIN, COORD_MAX);

    // Vehicle in the far corner, turned by pi/4: forward distance clamps.
    queue_cfg(rbr_pkg::CFG_CAR_X, COORD_MIN);
    queue_cfg(rbr_pkg::CFG_CAR_Y, COORD_MIN);
    queue_cfg(rbr_pkg::CFG_CAR_HEADING, CFG_W'(EIGHTH));
    queue_point(COORD_MAX, COORD_MAX);
    queue_point(COORD_MIN, COORD_MIN);
    queue_point(COORD_MAX, COORD_MIN);

    // Heading of -pi, whose negation wraps onto itself.
    queue_cfg(rbr_pkg::CFG_CAR_X, '0);
    queue_cfg(rbr_pkg::CFG_CAR_Y, '0);
    queue_cfg(rbr_pkg::CFG_CAR_HEADING, CFG_W'(HEAD_MIN));
    queue_point(1000, 0);
    queue_point(0, 1000);

    // Points straight behind: bearings round and wrap around pi.
    queue_cfg(rbr_pkg::CFG_CAR_HEADING, '0);
    queue_point(-1000000, 1);
    queue_point(-1000000, -1);
    queue_point(-1000000, 0);

    // Headings on the quadrant fold boundaries and the largest heading.
    queue_cfg(rbr_pkg::CFG_CAR_HEADING, CFG_W'(QUARTER));
    queue_point(5000, 7000);
    queue_cfg(rbr_pkg::CFG_CAR_HEADING, CFG_W'(-QUARTER));
    queue_point(5000, 7000);
    queue_cfg(rbr_pkg::CFG_CAR_HEADING, CFG_W'(HEAD_MAX));
    queue_point(1, 1);

    // A write to an unused index must leave the pose alone.
    queue_cfg(CFG_UNUSED, CFG_W'($urandom()));
    queue_point(123, -456);
    queue_drain();

    // Random phases, each after random writes to some pose registers.
    n_rand = 0;
    while (n_rand < RANDOM_POINTS) begin
      if ($urandom_range(0, 3) != 0) queue_cfg(rbr_pkg::CFG_CAR_X, pick_coord());
      if ($urandom_range(0, 3) != 0) queue_cfg(rbr_pkg::CFG_CAR_Y, pick_coord());
      if ($urandom_range(0, 3) != 0) begin
        // Fill the unused upper data bits with noise; only the low bits count.
        cfg_word = CFG_W'($urandom());
        cfg_word[ANGLE_BITS-1:0] = pick_heading();
        queue_cfg(rbr_pkg::CFG_CAR_HEADING, cfg_word);
      end
      if ($urandom_range(0, 9) == 0) queue_cfg(CFG_UNUSED, CFG_W'($urandom()));

      phase_len = $urandom_range(10, 80);
      for (int k = 0; k < phase_len && n_rand < RANDOM_POINTS; k++) begin
        case ($urandom_range(0, 15))
          0, 1, 2, 3, 4, 5: begin
            px = near_coord(plan_car_x, 4096);
            py = near_coord(plan_car_y, 4096);
          end
          13: begin
            px = pick_coord();
            py = pick_coord();
          end
          14: begin
            px = plan_car_x;
            py = plan_car_y;
          end
          15: begin
            px = near_coord(plan_car_x, 3);
            py = near_coord(plan_car_y, 3);
          end
          default: begin
            px = COORD_BITS'($urandom());
            py = COORD_BITS'($urandom());
          end
        endcase
        queue_point(px, py);
        n_rand++;
        if ($urandom_range(0, 39) == 0) queue_drain();
      end
    end

    // Reset once, release away from the active edge.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the whole plan to go out, then for the last words to land.
    do @(negedge clk_i); while (!stim_done);
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (outstanding != 0) begin
      $error("%0d result words never arrived", outstanding);
      err_count++;
    end
    // Watch a little longer for stray words.
    repeat (LATENCY + 8) @(negedge clk_i);

    if (err_count == 0) begin
      $display("tb_relative_bearing_and_range: PASS");
    end else begin
      $display("tb_relative_bearing_and_range: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rbr_pkg.sv
rtl/core/rbr_cordic_stage.sv
rtl/core/relative_bearing_and_range.sv
rtl/core/rbr_checker.sv
sim/tb_relative_bearing_and_range.sv
